[sv/mlasd_pkg.sv]
`default_nettype none

package mlasd_pkg;

   // Width of the meaningful part of each acceleration sample (8 to 16)
   localparam int ACCEL_BITS = 16;
   // Width of the tick and step counters (16 to 32)
   localparam int COUNT_BITS = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIGHT_THRESH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOTION_THRESH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_SAMPLES  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIST_THRESH   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_THRESH   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_MIN_GAP  = 3'd6;

   // Mode codes
   localparam logic MODE_STEP  = 1'b0;
   localparam logic MODE_WATCH = 1'b1;

   // Register values after reset
   localparam logic        RST_MODE          = MODE_STEP;
   localparam logic [15:0] RST_LIGHT_THRESH  = 16'd50;
   localparam logic [17:0] RST_MOTION_THRESH = 18'd3000;
   localparam logic [7:0]  RST_HOLD_SAMPLES  = 8'd15;
   localparam logic [12:0] RST_DIST_THRESH   = 13'd500;
   localparam logic [15:0] RST_STEP_THRESH   = 16'd500;
   localparam logic [7:0]  RST_STEP_MIN_GAP  = 8'd10;

   typedef struct packed {
      logic [15:0]        light_level;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [12:0]        distance;
   } req_type;

   typedef struct packed {
      logic        low_light;
      logic        fast_move;
      logic        outdoor;
      logic        step_seen;
      logic [31:0] step_total;
   } rsp_type;

   // Take the low ACCEL_BITS bits as a two's complement sample
   function automatic logic signed [ACCEL_BITS-1:0] accel_trim(input logic [15:0] raw);
      return $signed(raw[ACCEL_BITS-1:0]);
   endfunction

   // Absolute difference of two samples; fits in ACCEL_BITS bits unsigned
   function automatic logic [ACCEL_BITS-1:0] accel_absdiff(
      input logic signed [ACCEL_BITS-1:0] a,
      input logic signed [ACCEL_BITS-1:0] b
   );
      logic signed [ACCEL_BITS:0] d;
      logic        [ACCEL_BITS:0] m;
      d = {a[ACCEL_BITS-1], a} - {b[ACCEL_BITS-1], b};
      m = d[ACCEL_BITS] ? (ACCEL_BITS+1)'(-d) : d;
      return m[ACCEL_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[sv/motion_light_alarm_step_detector.sv]
`default_nettype none

// Motion, light and step detector.
//
// Input channel req_*: one sensor sample per transfer (light, three
// acceleration axes, ultrasonic distance). Result channel rsp_*: exactly one
// result per sample, in order. Configuration port csr_*: write enable, index
// and data, taken at once; write only while no sample is in flight.
//
// A transferred sample lands in the input register, is evaluated against the
// detector state and is written to the result register once that register is
// free, which raises rsp_valid. The evaluation is a single pass of compare and
// add logic, so one sample a cycle is sustained while the receiver takes every
// result; the 32-bit tick increment feeding the spacing subtract sets the
// longest path.
//
// Reset (synchronous, active high) empties both registers, clears all history
// and counters and loads the default thresholds. When the receiver stalls,
// the result holds in the result register and one further sample waits in the
// input register; req_ready drops only when both are full.
module motion_light_alarm_step_detector (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire mlasd_pkg::req_type                   req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output mlasd_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [mlasd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mlasd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mlasd_pkg::*;

   // Configuration registers
   logic        mode_ff;
   logic [15:0] light_thresh_ff;
   logic [17:0] motion_thresh_ff;
   logic [7:0]  hold_samples_ff;
   logic [12:0] dist_thresh_ff;
   logic [15:0] step_thresh_ff;
   logic [7:0]  step_min_gap_ff;

   // Input register and result register
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;

   // Detector state
   logic signed [ACCEL_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [ACCEL_BITS-1:0] prev_y_ff, prev_y_in;
   logic signed [ACCEL_BITS-1:0] prev_z_ff, prev_z_in;
   logic                         primed_ff, primed_in;
   logic [7:0]                   hold_left_ff, hold_left_in;
   logic [12:0]                  prev_dist_ff, prev_dist_in;
   logic                         outdoor_ff, outdoor_in;
   logic [COUNT_BITS-1:0]        tick_ff, tick_in;
   logic [COUNT_BITS-1:0]        last_step_ff, last_step_in;
   logic [COUNT_BITS-1:0]        step_count_ff, step_count_in;

   // Evaluation intermediates
   logic signed [ACCEL_BITS-1:0] ax, ay, az;
   logic [ACCEL_BITS-1:0]        dx, dy, dz;
   logic [17:0]                  change;
   logic [12:0]                  dist_jump;
   logic [COUNT_BITS-1:0]        tick_next, tick_gap;
   logic                         step_hit;
   logic                         advance;

   // Move the held sample into the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign ax = accel_trim(in_data_ff.accel_x);
   assign ay = accel_trim(in_data_ff.accel_y);
   assign az = accel_trim(in_data_ff.accel_z);
   assign dx = accel_absdiff(ax, prev_x_ff);
   assign dy = accel_absdiff(ay, prev_y_ff);
   assign dz = accel_absdiff(az, prev_z_ff);
   assign change = 18'(dx) + 18'(dy) + 18'(dz);

   assign dist_jump = (in_data_ff.distance > prev_dist_ff)
                    ? in_data_ff.distance - prev_dist_ff
                    : prev_dist_ff - in_data_ff.distance;

   // Spacing is measured modulo the counter width
   assign tick_next = tick_ff + COUNT_BITS'(1);
   assign tick_gap  = tick_next - last_step_ff;
   assign step_hit  = primed_ff && (17'(dx) > 17'(step_thresh_ff))
                    && (tick_gap > COUNT_BITS'(step_min_gap_ff));

   always_comb begin
      prev_x_in     = ax;
      prev_y_in     = prev_y_ff;
      prev_z_in     = prev_z_ff;
      primed_in     = 1'b1;
      hold_left_in  = hold_left_ff;
      prev_dist_in  = prev_dist_ff;
      outdoor_in    = outdoor_ff;
      tick_in       = tick_ff;
      last_step_in  = last_step_ff;
      step_count_in = step_count_ff;
      out_data_in   = '0;

      if (mode_ff == MODE_WATCH) begin
         out_data_in.low_light = in_data_ff.light_level < light_thresh_ff;
         // First sample only primes the history
         if (primed_ff) begin
            if (change > motion_thresh_ff) begin
               out_data_in.fast_move = 1'b1;
               hold_left_in          = hold_samples_ff;
            end else if (hold_left_ff != 8'd0) begin
               out_data_in.fast_move = 1'b1;
               hold_left_in          = hold_left_ff - 8'd1;
            end
         end
         // Keep the outdoor flag while there is no previous distance
         if (prev_dist_ff != 13'd0) begin
            outdoor_in = dist_jump > dist_thresh_ff;
         end
         out_data_in.outdoor = outdoor_in;
         prev_y_in    = ay;
         prev_z_in    = az;
         prev_dist_in = in_data_ff.distance;
      end else begin
         tick_in    = tick_next;
         outdoor_in = 1'b0;
         if (step_hit) begin
            step_count_in         = step_count_ff + COUNT_BITS'(1);
            last_step_in          = tick_next;
            out_data_in.step_seen = 1'b1;
         end
      end
      out_data_in.step_total = 32'(step_count_in);
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= RST_MODE;
         light_thresh_ff  <= RST_LIGHT_THRESH;
         motion_thresh_ff <= RST_MOTION_THRESH;
         hold_samples_ff  <= RST_HOLD_SAMPLES;
         dist_thresh_ff   <= RST_DIST_THRESH;
         step_thresh_ff   <= RST_STEP_THRESH;
         step_min_gap_ff  <= RST_STEP_MIN_GAP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:          mode_ff          <= csr_wdata[0];
            CSR_LIGHT_THRESH:  light_thresh_ff  <= csr_wdata[15:0];
            CSR_MOTION_THRESH: motion_thresh_ff <= csr_wdata[17:0];
            CSR_HOLD_SAMPLES:  hold_samples_ff  <= csr_wdata[7:0];
            CSR_DIST_THRESH:   dist_thresh_ff   <= csr_wdata[12:0];
            CSR_STEP_THRESH:   step_thresh_ff   <= csr_wdata[15:0];
            CSR_STEP_MIN_GAP:  step_min_gap_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Handshake control and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
         primed_ff     <= 1'b0;
         hold_left_ff  <= '0;
         prev_dist_ff  <= '0;
         outdoor_ff    <= 1'b0;
         tick_ff       <= '0;
         last_step_ff  <= '0;
         step_count_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            prev_x_ff     <= prev_x_in;
            prev_y_ff     <= prev_y_in;
            prev_z_ff     <= prev_z_in;
            primed_ff     <= primed_in;
            hold_left_ff  <= hold_left_in;
            prev_dist_ff  <= prev_dist_in;
            outdoor_ff    <= outdoor_in;
            tick_ff       <= tick_in;
            last_step_ff  <= last_step_in;
            step_count_ff <= step_count_in;
         end
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

[sv/mlasd_checker.sv]
`default_nettype none

module mlasd_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire mlasd_pkg::rsp_type                   rsp_data
);
   import mlasd_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // Empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // A counted step comes from step mode, where all flags read zero
   a_step_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_seen |->
         !rsp_data.low_light && !rsp_data.fast_move && !rsp_data.outdoor)
      else $error("alert flag raised with a counted step");

   // A free result register must not block the input side
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

endmodule

bind motion_light_alarm_step_detector mlasd_checker u_mlasd_checker (.*);

`default_nettype wire

[tb/tb_motion_light_alarm_step_detector.sv]
`timescale 1ns / 100ps

module tb_motion_light_alarm_step_detector;
   import mlasd_pkg::*;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 55;
   localparam int MAX_GAP       = 40;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   motion_light_alarm_step_detector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Pressure knobs, in percent of cycles
   int idle_pct  = 0;
   int stall_pct = 0;
   int error_count = 0;

   // Results still owed by the block, oldest first
   rsp_type awaited_rsp[$];

   // Register copies, at their post-reset values
   logic        cfg_mode     = MODE_STEP;
   logic [15:0] cfg_light    = 16'd50;
   logic [17:0] cfg_motion   = 18'd3000;
   logic [7:0]  cfg_hold     = 8'd15;
   logic [12:0] cfg_dist     = 13'd500;
   logic [15:0] cfg_step_thr = 16'd500;
   logic [7:0]  cfg_gap      = 8'd10;

   // Detector history, cleared as after reset
   int                    hist_x = 0;
   int                    hist_y = 0;
   int                    hist_z = 0;
   bit                    primed = 1'b0;
   logic [7:0]            hold_left = '0;
   logic [12:0]           hist_dist = '0;
   bit                    outdoor_flag = 1'b0;
   logic [COUNT_BITS-1:0] tick_count = '0;
   logic [COUNT_BITS-1:0] last_step_tick = '0;
   logic [COUNT_BITS-1:0] step_count = '0;

   // Stimulus-side memory of the last sample, so that random samples can
   // drift gently instead of always jumping
   logic signed [15:0] stim_x = '0;
   logic signed [15:0] stim_y = '0;
   logic signed [15:0] stim_z = '0;
   logic [12:0]        stim_dist = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_motion_light_alarm_step_detector: FAIL");
      $finish;
   end

   // Receiver: stall at random according to the current phase
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic int axis_delta(input int a, input int b);
      int d;
      d = a - b;
      return (d < 0) ? -d : d;
   endfunction

   // Take the low ACCEL_BITS bits of a raw axis field as a signed sample
   function automatic int axis_value(input logic [15:0] raw);
      return int'($signed(raw[ACCEL_BITS-1:0]));
   endfunction

   // Advance the detector copy by one sample and give the result it owes
   function automatic rsp_type evaluate_sample(input req_type s);
      rsp_type     r;
      int          ax;
      int          ay;
      int          az;
      int          change;
      logic [12:0] jump;
      r  = '0;
      ax = axis_value(s.accel_x);
      ay = axis_value(s.accel_y);
      az = axis_value(s.accel_z);
      if (cfg_mode == MODE_WATCH) begin
         r.low_light = (s.light_level < cfg_light);
         if (primed) begin
            change = axis_delta(ax, hist_x) + axis_delta(ay, hist_y) + axis_delta(az, hist_z);
            if (change > cfg_motion) begin
               r.fast_move = 1'b1;
               hold_left   = cfg_hold;
            end else if (hold_left != 0) begin
               hold_left   = hold_left - 1'b1;
               r.fast_move = 1'b1;
            end
         end else begin
            primed = 1'b1;
         end
         // A zero previous distance means no reading: keep the flag as it is
         if (hist_dist != 0) begin
            jump = (s.distance > hist_dist) ? s.distance - hist_dist : hist_dist - s.distance;
            outdoor_flag = (jump > cfg_dist);
         end
         r.outdoor = outdoor_flag;
         hist_x    = ax;
         hist_y    = ay;
         hist_z    = az;
         hist_dist = s.distance;
      end else begin
         tick_count   = tick_count + 1'b1;
         outdoor_flag = 1'b0;
         if (!primed) begin
            primed = 1'b1;
         end else if (axis_delta(ax, hist_x) > cfg_step_thr &&
                      COUNT_BITS'(tick_count - last_step_tick) > cfg_gap) begin
            step_count     = step_count + 1'b1;
            last_step_tick = tick_count;
            r.step_seen    = 1'b1;
         end
         hist_x = ax;
      end
      r.step_total = 32'(step_count);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Compare every result transfer with the oldest outstanding prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual %0h", $time, rsp_data);
         end else begin
            want = awaited_rsp.pop_front();
            check_field("low_light",  32'(want.low_light),  32'(rsp_data.low_light));
            check_field("fast_move",  32'(want.fast_move),  32'(rsp_data.fast_move));
            check_field("outdoor",    32'(want.outdoor),    32'(rsp_data.outdoor));
            check_field("step_seen",  32'(want.step_seen),  32'(rsp_data.step_seen));
            check_field("step_total", want.step_total, rsp_data.step_total);
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Number of idle cycles before the next sample, geometric in idle_pct
   function automatic int pick_gap();
      int g;
      g = 0;
      while (g < MAX_GAP && $urandom_range(99) < idle_pct) g++;
      return g;
   endfunction

   // Offer one sample, hold it until the transfer, then log its prediction.
   // Valid is left high so that back-to-back samples need no extra edge.
   task automatic send_sample(input req_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      awaited_rsp.push_back(evaluate_sample(s));
   endtask

   // Drop valid, then wait until every owed result has come back
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write one register with the block idle and mirror it, masked to width
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_MODE:          cfg_mode     = data[0];
         CSR_LIGHT_THRESH:  cfg_light    = data[15:0];
         CSR_MOTION_THRESH: cfg_motion   = data[17:0];
         CSR_HOLD_SAMPLES:  cfg_hold     = data[7:0];
         CSR_DIST_THRESH:   cfg_dist     = data[12:0];
         CSR_STEP_THRESH:   cfg_step_thr = data[15:0];
         CSR_STEP_MIN_GAP:  cfg_gap      = data[7:0];
         default: ;
      endcase
   endtask

   function automatic req_type pack_sample(input logic [15:0] light,
                                           input logic [15:0] x,
                                           input logic [15:0] y,
                                           input logic [15:0] z,
                                           input logic [12:0] range_raw);
      req_type s;
      s.light_level = light;
      s.accel_x     = x;
      s.accel_y     = y;
      s.accel_z     = z;
      s.distance    = range_raw;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Random generation
   // ------------------------------------------------------------------

   // Mostly drift or moderate jumps, with some noise and rail values
   function automatic req_type make_sample();
      int pick;
      int dpick;
      logic [15:0] light;
      pick = $urandom_range(99);
      if (pick < 15) begin
         stim_x = 16'($urandom);
         stim_y = 16'($urandom);
         stim_z = 16'($urandom);
      end else if (pick < 65) begin
         stim_x = stim_x + 16'($urandom_range(1200)) - 16'd600;
         stim_y = stim_y + 16'($urandom_range(1200)) - 16'd600;
         stim_z = stim_z + 16'($urandom_range(1200)) - 16'd600;
      end else if (pick < 90) begin
         stim_x = stim_x + 16'($urandom_range(40000)) - 16'd20000;
         stim_y = stim_y + 16'($urandom_range(8000)) - 16'd4000;
         stim_z = stim_z + 16'($urandom_range(8000)) - 16'd4000;
      end else begin
         stim_x = $urandom_range(1) ? 16'h7FFF : 16'h8000;
         stim_y = $urandom_range(1) ? 16'h7FFF : 16'h8000;
         stim_z = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      end
      dpick = $urandom_range(7);
      case (dpick)
         0:       stim_dist = '0;
         1:       stim_dist = 13'h1FFF;
         2, 3:    stim_dist = 13'($urandom);
         default: stim_dist = stim_dist + 13'($urandom_range(1200)) - 13'd600;
      endcase
      // Hover around the threshold half the time to hit both sides of it
      if ($urandom_range(1))
         light = 16'($urandom);
      else
         light = cfg_light + 16'($urandom_range(6)) - 16'd3;
      return pack_sample(light, stim_x, stim_y, stim_z, stim_dist);
   endfunction

   // Zero, the top of the range, a typical value or anything in range
   function automatic logic [CSR_DATA_BITS-1:0] rand_reg(input int max, input int typical);
      case ($urandom_range(3))
         0:       return '0;
         1:       return CSR_DATA_BITS'(max);
         2:       return CSR_DATA_BITS'($urandom_range(typical));
         default: return CSR_DATA_BITS'($urandom_range(max));
      endcase
   endfunction

   // Sometimes dirty the bits above a register's width; they must be dropped
   function automatic logic [CSR_DATA_BITS-1:0] with_junk(input logic [CSR_DATA_BITS-1:0] v,
                                                          input int width);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'($urandom) << width;
      return $urandom_range(1) ? (v | junk) : v;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Default registers, step mode: first sample only primes, then rail-to-rail
   // X swings count a step only once the tick spacing exceeds the minimum gap
   task automatic test_step_counting();
      int i;
      for (i = 0; i < 12; i++) begin
         send_sample(pack_sample(i[0] ? 16'hFFFF : 16'h0000,
                                 i[0] ? 16'h8000 : 16'h7FFF,
                                 i[0] ? 16'h7FFF : 16'h8000,
                                 i[0] ? 16'h8000 : 16'h7FFF,
                                 i[0] ? 13'h1FFF : 13'h0000));
      end
   endtask

   // Alert mode: low light on both sides of the threshold, fast move with its
   // hold, outdoor held while the previous distance reads zero
   task automatic test_alert_flags();
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_WATCH));
      send_sample(pack_sample(16'd0,     16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd0));
      send_sample(pack_sample(16'hFFFF,  16'h8000, 16'h8000, 16'h8000, 13'h1FFF));
      send_sample(pack_sample(16'd49,    16'h8000, 16'h8000, 16'h8000, 13'd0));
      send_sample(pack_sample(16'd50,    16'h8000, 16'h8000, 16'h8000, 13'd100));
      send_sample(pack_sample(16'd50,    16'h8000, 16'h8000, 16'h8000, 13'd601));
      send_sample(pack_sample(16'd50,    16'h8000, 16'h8000, 16'h8000, 13'd1101));
      // Largest possible change against an equal threshold: never exceeds
      write_reg(CSR_HOLD_SAMPLES, '0);
      write_reg(CSR_MOTION_THRESH, 18'd196605);
      send_sample(pack_sample(16'd51,    16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd1101));
      // Zero threshold with zero hold: a one-count change flags a single sample
      write_reg(CSR_MOTION_THRESH, '0);
      send_sample(pack_sample(16'd51,    16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd1101));
      send_sample(pack_sample(16'd51,    16'h7FFE, 16'h7FFF, 16'h7FFF, 13'd1101));
      send_sample(pack_sample(16'd51,    16'h7FFE, 16'h7FFF, 16'h7FFF, 13'd1101));
   endtask

   // Step mode clears outdoor; a write to a missing index changes nothing
   task automatic test_mode_return();
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_STEP));
      send_sample(pack_sample(16'd0, 16'h0000, 16'h1234, 16'h4321, 13'd4000));
      write_reg(CSR_UNUSED_INDEX, '1);
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_WATCH));
      send_sample(pack_sample(16'd60, 16'h0000, 16'h0000, 16'h0000, 13'd1101));
      write_reg(CSR_LIGHT_THRESH, 18'hFFFF);
      send_sample(pack_sample(16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 13'd1101));
   endtask

   // One random phase: fresh registers, a pressure pattern, then samples
   task automatic test_random_traffic(input int phase);
      int  i;
      logic mode_sel;
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 78; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 78; end
         default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      mode_sel = 1'(((phase / 4) ^ phase) & 1);
      write_reg(CSR_MODE,          with_junk(CSR_DATA_BITS'(mode_sel), 1));
      write_reg(CSR_LIGHT_THRESH,  with_junk(rand_reg(65535, 1000), 16));
      write_reg(CSR_MOTION_THRESH, rand_reg(196605, 20000));
      write_reg(CSR_HOLD_SAMPLES,  with_junk(rand_reg(255, 8), 8));
      write_reg(CSR_DIST_THRESH,   with_junk(rand_reg(8191, 1000), 13));
      write_reg(CSR_STEP_THRESH,   with_junk(rand_reg(65535, 3000), 16));
      write_reg(CSR_STEP_MIN_GAP,  with_junk(rand_reg(255, 20), 8));
      if ($urandom_range(3) == 0)
         write_reg(CSR_UNUSED_INDEX, CSR_DATA_BITS'($urandom));
      for (i = 0; i < PHASE_SAMPLES; i++)
         send_sample(make_sample());
      settle_idle();
   endtask

   initial begin : main
      int p;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_step_counting();
      test_alert_flags();
      test_mode_return();
      for (p = 0; p < RANDOM_PHASES; p++)
         test_random_traffic(p);

      // Let any trailing transfer land before judging
      settle_idle();
      repeat (5) @(posedge clock);
      if (error_count == 0 && awaited_rsp.size() == 0) begin
         $display("tb_motion_light_alarm_step_detector: PASS");
      end else begin
         $display("tb_motion_light_alarm_step_detector: FAIL");
      end
      $finish;
   end

endmodule
